// ===== rtl/fat12_cluster_chain_reader_core_macros.svh =====
// Assertion shorthands shared by the checker.
`ifndef FAT12_CLUSTER_CHAIN_READER_CORE_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_READER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define FCR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcr check failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define FCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcr check failed");

`endif

// ===== rtl/fcr_pkg.sv =====
package fcr_pkg;

  // Command codes on the func field
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_OPEN    = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_DATA_START = 1'b0;
  localparam logic REG_SPC        = 1'b1;

  localparam int PADDR_W = 3;

  // First cluster value that marks the end of a chain
  localparam logic [11:0] CHAIN_END = 12'hFF8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic tbl_write;
    logic open_load;
    logic calc;
    logic rd_hi;
    logic fetch_lo;
    logic fetch_hi;
    logic emit;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;
    logic emit_ok;
    logic emit_last;
  } status_t;

  function automatic logic chain_ends(input logic [11:0] clus);
    return (clus < 12'd2) || (clus >= CHAIN_END);
  endfunction

endpackage

// ===== rtl/fcr_regs.sv =====
module fcr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 data_start_lba,
  output logic [6:0]                  clus_sectors
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the addressed register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      data_start_lba <= 32'd0;
      clus_sectors   <= 7'd1;
    end else if (wr_en) begin
      unique case (paddr[2])
        fcr_pkg::REG_DATA_START: data_start_lba <= pwdata;
        fcr_pkg::REG_SPC:        clus_sectors   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      fcr_pkg::REG_DATA_START: prdata = data_start_lba;
      fcr_pkg::REG_SPC:        prdata = {25'd0, clus_sectors};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/fcr_ctrl.sv =====
module fcr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       func,
  input  fcr_pkg::status_t status,
  output fcr_pkg::cmd_t    cmd,
  output logic             busy
);

  fcr_pkg::state_t state, state_next;
  logic            accept;

  assign busy   = (state != fcr_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fcr_pkg::ST_IDLE: begin
        if (accept && (func == fcr_pkg::FUNC_OPEN || func == fcr_pkg::FUNC_ADVANCE)) begin
          state_next = fcr_pkg::ST_CHECK;
        end
      end
      fcr_pkg::ST_CHECK: begin
        state_next = status.active ? fcr_pkg::ST_FETCH_LO : fcr_pkg::ST_IDLE;
      end
      fcr_pkg::ST_FETCH_LO: state_next = fcr_pkg::ST_FETCH_HI;
      fcr_pkg::ST_FETCH_HI: state_next = fcr_pkg::ST_EMIT;
      fcr_pkg::ST_EMIT: begin
        if (!status.emit_ok || status.emit_last) begin
          state_next = fcr_pkg::ST_IDLE;
        end
      end
      default: state_next = fcr_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    unique case (state)
      fcr_pkg::ST_IDLE: begin
        cmd.tbl_write = accept && (func == fcr_pkg::FUNC_LOAD);
        cmd.open_load = accept && (func == fcr_pkg::FUNC_OPEN);
      end
      fcr_pkg::ST_CHECK: cmd.calc = status.active;
      fcr_pkg::ST_FETCH_LO: begin
        cmd.fetch_lo = 1'b1;
        cmd.rd_hi    = 1'b1;
      end
      fcr_pkg::ST_FETCH_HI: cmd.fetch_hi = 1'b1;
      fcr_pkg::ST_EMIT: begin
        cmd.emit   = status.emit_ok;
        cmd.commit = !status.emit_ok || status.emit_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/fcr_datapath.sv =====
module fcr_datapath #(
  parameter int TABLE_BYTES         = 8192,
  parameter int SECTOR_BYTES        = 512,
  parameter int MAX_CLUSTER_SECTORS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  fcr_pkg::cmd_t    cmd,
  output fcr_pkg::status_t status,
  input  logic [12:0]      table_address,
  input  logic [7:0]       table_byte,
  input  logic [11:0]      start_cluster,
  input  logic [31:0]      file_size,
  input  logic [31:0]      data_start_lba,
  input  logic [6:0]       clus_sectors,
  output logic             strobe,
  output logic [31:0]      sector_lba,
  output logic [9:0]       byte_count,
  output logic             last_of_item,
  output logic             file_done
);

  localparam int TBL_AW = $clog2(TABLE_BYTES);
  localparam int SEC_W  = $clog2(MAX_CLUSTER_SECTORS + 1);
  localparam int PROD_W = 12 + SEC_W;
  localparam int CNT_W  = $clog2(SECTOR_BYTES + 1);

  logic [7:0]        mem [TABLE_BYTES];
  logic [7:0]        rd_data;
  logic [11:0]       current_cluster;
  logic [31:0]       bytes_remaining;
  logic [PROD_W-1:0] base_prod;
  logic [31:0]       base_lba;
  logic [7:0]        lo_byte;
  logic [11:0]       next_cluster;
  logic [SEC_W-1:0]  sector_idx;

  logic [SEC_W-1:0]  spc_eff;
  logic [12:0]       tbl_off;
  logic [12:0]       rd_off;
  logic              wr_in_range;
  logic [CNT_W-1:0]  cnt;
  logic [31:0]       rem_after;
  logic              sec_last;

  // Clamp the sector count to what the counter supports
  always_comb begin
    if (8'(clus_sectors) > 8'(MAX_CLUSTER_SECTORS)) begin
      spc_eff = SEC_W'(MAX_CLUSTER_SECTORS);
    end else begin
      spc_eff = SEC_W'(clus_sectors);
    end
  end

  // Entry of cluster c sits at byte c + c/2; with the default TABLE_BYTES the offset never passes the table end
  assign tbl_off     = 13'(current_cluster) + 13'(current_cluster[11:1]);
  assign rd_off      = cmd.rd_hi ? (tbl_off + 13'd1) : tbl_off;
  assign wr_in_range = (17'(table_address) < 17'(TABLE_BYTES));

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.tbl_write && wr_in_range) begin
      mem[TBL_AW'(table_address)] <= table_byte;
    end
    rd_data <= mem[TBL_AW'(rd_off)];
  end

  // Per-sector arithmetic
  always_comb begin
    if (bytes_remaining < 32'(SECTOR_BYTES)) begin
      cnt = CNT_W'(bytes_remaining);
    end else begin
      cnt = CNT_W'(SECTOR_BYTES);
    end
  end

  assign rem_after = bytes_remaining - 32'(cnt);
  assign sec_last  = (({1'b0, sector_idx} + (SEC_W+1)'(1)) == {1'b0, spc_eff});

  assign status.active    = (bytes_remaining != 32'd0) && !fcr_pkg::chain_ends(current_cluster);
  assign status.emit_ok   = (sector_idx < spc_eff) && (bytes_remaining != 32'd0);
  assign status.emit_last = (rem_after == 32'd0) || sec_last;

  // Chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_cluster <= 12'd0;
      bytes_remaining <= 32'd0;
    end else begin
      if (cmd.open_load) begin
        current_cluster <= start_cluster;
        bytes_remaining <= file_size;
      end
      if (cmd.emit) begin
        bytes_remaining <= rem_after;
      end
      if (cmd.commit) begin
        current_cluster <= next_cluster;
      end
    end
  end

  // Cluster setup: base LBA and next entry
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      base_prod  <= PROD_W'(current_cluster - 12'd2) * PROD_W'(spc_eff);
      sector_idx <= '0;
    end
    if (cmd.fetch_lo) begin
      lo_byte  <= rd_data;
      base_lba <= data_start_lba + 32'(base_prod);
    end
    if (cmd.fetch_hi) begin
      // odd clusters take the high twelve bits of the word
      next_cluster <= current_cluster[0] ? {rd_data, lo_byte[7:4]}
                                         : {rd_data[3:0], lo_byte};
    end
    if (cmd.emit) begin
      sector_idx <= sector_idx + SEC_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sector_lba   <= base_lba + 32'(sector_idx);
      byte_count   <= 10'(cnt);
      last_of_item <= status.emit_last;
      file_done    <= (rem_after == 32'd0) || (sec_last && fcr_pkg::chain_ends(next_cluster));
    end
  end

endmodule

// ===== rtl/fat12_cluster_chain_reader_core.sv =====
// FAT12 cluster chain reader. Load the allocation table with func=0 (one byte
// per transaction, busy stays low), then open a file with func=1 and step with
// func=2. Each open or advance walks the current cluster: after the accept
// cycle it does the end-of-chain check and the LBA multiply in ST_CHECK,
// reads the 12-bit next entry through the table's single read port in
// ST_FETCH_LO and ST_FETCH_HI, then emits one result per sector, one per
// cycle, until the cluster or the file ends (none with a zero sector count;
// it goes idle after ST_CHECK if the chain has already ended). Results appear
// on sector_lba/byte_count/last_of_item/file_done for exactly one cycle with
// strobe high; the receiver cannot stall them, so it must take every strobe.
// Start is accepted only while busy is low. Write configuration only while idle.
module fat12_cluster_chain_reader_core #(
  parameter int TABLE_BYTES         = 8192,
  parameter int SECTOR_BYTES        = 512,
  parameter int MAX_CLUSTER_SECTORS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func,
  input  logic [12:0]                 table_address,
  input  logic [7:0]                  table_byte,
  input  logic [11:0]                 start_cluster,
  input  logic [31:0]                 file_size,
  output logic                        strobe,
  output logic [31:0]                 sector_lba,
  output logic [9:0]                  byte_count,
  output logic                        last_of_item,
  output logic                        file_done
);

  logic [31:0]      data_start_lba;
  logic [6:0]       clus_sectors;
  fcr_pkg::cmd_t    cmd;
  fcr_pkg::status_t status;

  fcr_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .data_start_lba (data_start_lba),
    .clus_sectors   (clus_sectors)
  );

  fcr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fcr_datapath #(
    .TABLE_BYTES         (TABLE_BYTES),
    .SECTOR_BYTES        (SECTOR_BYTES),
    .MAX_CLUSTER_SECTORS (MAX_CLUSTER_SECTORS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .table_address  (table_address),
    .table_byte     (table_byte),
    .start_cluster  (start_cluster),
    .file_size      (file_size),
    .data_start_lba (data_start_lba),
    .clus_sectors   (clus_sectors),
    .strobe         (strobe),
    .sector_lba     (sector_lba),
    .byte_count     (byte_count),
    .last_of_item   (last_of_item),
    .file_done      (file_done)
  );

endmodule

// ===== rtl/fcr_checker.sv =====
`include "fat12_cluster_chain_reader_core_macros.svh"

module fcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func,
  input logic        strobe,
  input logic [31:0] sector_lba,
  input logic        last_of_item,
  input logic        file_done
);

  // Sectors of one cluster come out back to back
  `FCR_ASSERT_NEXT(a_burst_continues, strobe && !last_of_item, strobe)

  // Consecutive sectors within a cluster have consecutive LBAs
  `FCR_ASSERT_NEXT(a_lba_steps, strobe && !last_of_item, sector_lba == $past(sector_lba) + 32'd1)

  // The end of a file always closes the transaction's burst
  `FCR_ASSERT_SAME(a_done_is_last, strobe && file_done, last_of_item)

  // Table loads and unknown codes neither stall nor produce results
  `FCR_ASSERT_NEXT(a_load_quiet, start && !busy && func != fcr_pkg::FUNC_OPEN && func != fcr_pkg::FUNC_ADVANCE, !busy && !strobe)

endmodule

bind fat12_cluster_chain_reader_core fcr_checker u_checker (.*);
